FILE: rtl/dcf_pkg.sv
// Shared types, constants and the Bayer table of the dithered column fill.
// Used by dcf_div and dithered_column_fill_core; depends on nothing.
package dcf_pkg;

    // Parameter defaults
    localparam int unsigned MAX_HEIGHT_DEF = 64;
    localparam int unsigned MAX_WIDTH_DEF  = 1024;

    // Register map: index of each register (byte address is 4 * index)
    localparam logic [2:0] REG_CELL_SIZE      = 3'd0;
    localparam logic [2:0] REG_CANVAS_WIDTH   = 3'd1;
    localparam logic [2:0] REG_CANVAS_HEIGHT  = 3'd2;
    localparam logic [2:0] REG_OFF_TIER_ALPHA = 3'd3;
    localparam logic [2:0] REG_BORDER_ALPHA   = 3'd4;

    // Register reset values
    localparam logic [3:0]  CELL_SIZE_RST      = 4'd1;
    localparam logic [10:0] CANVAS_WIDTH_RST   = 11'd240;
    localparam logic [6:0]  CANVAS_HEIGHT_RST  = 7'd64;
    localparam logic [15:0] OFF_TIER_ALPHA_RST = 16'd16384;
    localparam logic [15:0] BORDER_ALPHA_RST   = 16'd32768;

    // Alpha ramp in Q0.16: 0.30 base plus 0.70 span, half-LSB rounding
    localparam logic [15:0] K_BASE     = 16'd19661;
    localparam logic [15:0] K_SPAN     = 16'd45875;
    localparam logic [15:0] ROUND_HALF = 16'd32768;

    // Shared divider widths
    localparam int unsigned DIV_W   = 16;
    localparam int unsigned DIVS_W  = 7;
    localparam int unsigned DIVC_W  = $clog2(DIV_W);

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_W-1:0]  quotient;
        logic [DIVS_W-1:0] remainder;
    } div_rsp_t;

    // 4x4 Bayer threshold matrix, indexed by cell row and cell column
    function automatic logic [3:0] bayer_threshold(input logic [1:0] cy, input logic [1:0] cx);
        logic [3:0] b;
        unique case ({cy, cx})
            4'h0: b = 4'd0;
            4'h1: b = 4'd8;
            4'h2: b = 4'd2;
            4'h3: b = 4'd10;
            4'h4: b = 4'd12;
            4'h5: b = 4'd4;
            4'h6: b = 4'd14;
            4'h7: b = 4'd6;
            4'h8: b = 4'd3;
            4'h9: b = 4'd11;
            4'hA: b = 4'd1;
            4'hB: b = 4'd9;
            4'hC: b = 4'd15;
            4'hD: b = 4'd7;
            4'hE: b = 4'd13;
            4'hF: b = 4'd5;
            default: b = 4'd0;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/dcf_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, shared by the fill sequencer.
// Depends on dcf_pkg (widths and request/response structs).
module dcf_div (
    input  logic              clk,
    input  logic              rst_n,
    input  dcf_pkg::div_req_t req,
    output dcf_pkg::div_rsp_t rsp
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [dcf_pkg::DIVC_W-1:0]    cnt_reg, cnt_next;
    logic [dcf_pkg::DIV_W-1:0]     dvd_reg, dvd_next;
    logic [dcf_pkg::DIVS_W-1:0]    rem_reg, rem_next;
    logic [dcf_pkg::DIVS_W-1:0]    dvs_reg, dvs_next;
    logic [dcf_pkg::DIVS_W:0]      rem_sh;
    logic                          q_bit;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        rem_sh    = {rem_reg, dvd_reg[dcf_pkg::DIV_W-1]};
        q_bit     = (rem_sh >= {1'b0, dvs_reg});
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when it fits
            rem_next = q_bit ? (dcf_pkg::DIVS_W)'(rem_sh - {1'b0, dvs_reg})
                             : rem_sh[dcf_pkg::DIVS_W-1:0];
            dvd_next = {dvd_reg[dcf_pkg::DIV_W-2:0], q_bit};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == (dcf_pkg::DIVC_W)'(dcf_pkg::DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = dvd_reg;
    assign rsp.remainder = rem_reg;

endmodule

FILE: rtl/dithered_column_fill_core.sv
// Top level of the dithered column fill: APB register file, fill sequencer, output word register.
// Depends on dcf_pkg and dcf_div.
//
// One request paints one column with a 4x4 ordered-dither fill and returns one word per row
// in ascending row order, the final word marked by last. A request whose column lies off the
// canvas, or whose span is empty and starts below the canvas, returns nothing. in_stall stays
// high for the whole request. Setup runs three divisions on one shared restoring divider
// (column by cell size, top row by cell size, alpha span by depth); after that every row
// steps through threshold compare, alpha multiply and channel scaling, and waits while
// out_stall holds the output word. An empty span skips setup and goes straight to the
// output state with the border alpha, where its single border word is loaded once the
// output register is free.
// Registers must be written only while no request is in flight.
module dithered_column_fill_core #(
    parameter int unsigned MAX_HEIGHT = dcf_pkg::MAX_HEIGHT_DEF,
    parameter int unsigned MAX_WIDTH  = dcf_pkg::MAX_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // request channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [9:0]         column_x,
    input  logic signed [7:0]  top_row,
    input  logic signed [8:0]  floor_row,
    input  logic [15:0]        color,
    // pixel channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [5:0]         row,
    output logic [15:0]        pixel,
    output logic               last
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIVX = 3'd1;
    localparam logic [2:0] S_DIVY = 3'd2;
    localparam logic [2:0] S_DIVK = 3'd3;
    localparam logic [2:0] S_ROWA = 3'd4;
    localparam logic [2:0] S_ROWM = 3'd5;
    localparam logic [2:0] S_PIX  = 3'd6;

    // ---------------- configuration registers ----------------
    logic [3:0]  cell_size_reg;
    logic [10:0] canvas_width_reg;
    logic [6:0]  canvas_height_reg;
    logic [15:0] off_tier_alpha_reg;
    logic [15:0] border_alpha_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_size_reg      <= dcf_pkg::CELL_SIZE_RST;
            canvas_width_reg   <= dcf_pkg::CANVAS_WIDTH_RST;
            canvas_height_reg  <= dcf_pkg::CANVAS_HEIGHT_RST;
            off_tier_alpha_reg <= dcf_pkg::OFF_TIER_ALPHA_RST;
            border_alpha_reg   <= dcf_pkg::BORDER_ALPHA_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[4:2])
                dcf_pkg::REG_CELL_SIZE:      cell_size_reg      <= pwdata[3:0];
                dcf_pkg::REG_CANVAS_WIDTH:   canvas_width_reg   <= pwdata[10:0];
                dcf_pkg::REG_CANVAS_HEIGHT:  canvas_height_reg  <= pwdata[6:0];
                dcf_pkg::REG_OFF_TIER_ALPHA: off_tier_alpha_reg <= pwdata[15:0];
                dcf_pkg::REG_BORDER_ALPHA:   border_alpha_reg   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            dcf_pkg::REG_CELL_SIZE:      prdata = {28'b0, cell_size_reg};
            dcf_pkg::REG_CANVAS_WIDTH:   prdata = {21'b0, canvas_width_reg};
            dcf_pkg::REG_CANVAS_HEIGHT:  prdata = {25'b0, canvas_height_reg};
            dcf_pkg::REG_OFF_TIER_ALPHA: prdata = {16'b0, off_tier_alpha_reg};
            dcf_pkg::REG_BORDER_ALPHA:   prdata = {16'b0, border_alpha_reg};
            default:                     prdata = '0;
        endcase
    end

    // ---------------- request decode ----------------
    logic [3:0]        cs_eff;
    logic [10:0]       w_eff;
    logic [6:0]        h_eff;
    logic [6:0]        top_c;
    logic signed [8:0] floor_c;
    logic [9:0]        depth_s;
    logic              depth_pos;
    logic              x_off;
    logic              top_in;
    logic [6:0]        floor_m1;

    assign cs_eff = (cell_size_reg == 4'd0) ? 4'd1 : cell_size_reg;
    assign w_eff  = (32'(canvas_width_reg) > MAX_WIDTH) ? 11'(MAX_WIDTH) : canvas_width_reg;
    assign h_eff  = (32'(canvas_height_reg) > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : canvas_height_reg;
    assign top_c  = top_row[7] ? 7'd0 : top_row[6:0];
    assign floor_c = (floor_row > $signed({2'b00, h_eff})) ? $signed({2'b00, h_eff}) : floor_row;
    assign depth_s   = {floor_c[8], floor_c} - {3'b000, top_c};
    assign depth_pos = !depth_s[9] && (depth_s != 10'd0);
    assign x_off     = ({1'b0, column_x} >= w_eff);
    assign top_in    = (top_c < h_eff);
    assign floor_m1  = floor_c[6:0] - 7'd1;

    // ---------------- sequencer ----------------
    logic [2:0]  state_reg, state_next;
    logic [5:0]  y_reg, y_next;
    logic [5:0]  end_reg, end_next;
    logic [5:0]  d_reg, d_next;
    logic [6:0]  depth_reg, depth_next;
    logic [5:0]  top_reg, top_next;
    logic [15:0] color_reg, color_next;
    logic [1:0]  xcell_reg, xcell_next;
    logic [1:0]  ycell_reg, ycell_next;
    logic [3:0]  yrem_reg, yrem_next;
    logic [15:0] q0_reg, q0_next;
    logic [6:0]  r0_reg, r0_next;
    logic [15:0] q_reg, q_next;
    logic [6:0]  r_reg, r_next;
    logic [15:0] k_reg, k_next;
    logic        lit_reg, lit_next;
    logic [15:0] alpha_reg, alpha_next;

    logic        out_valid_reg, out_valid_next;
    logic [5:0]  row_reg, row_next;
    logic [15:0] pixel_reg, pixel_next;
    logic        last_reg, last_next;

    dcf_pkg::div_req_t div_req;
    dcf_pkg::div_rsp_t div_rsp;

    dcf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    logic        accept;
    logic        out_free;
    logic        out_load;
    logic [3:0]  bayer_b;
    logic [11:0] thr_rhs;
    logic [11:0] thr_lhs;
    logic [31:0] unlit_prod;
    logic [16:0] feather_sum;
    logic [7:0]  r_sum;
    logic        r_wrap;
    logic [20:0] red_prod;
    logic [21:0] grn_prod;
    logic [20:0] blu_prod;
    logic [21:0] red_rnd;
    logic [22:0] grn_rnd;
    logic [21:0] blu_rnd;
    logic        row_last;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign row_last = (y_reg == end_reg);

    assign bayer_b     = dcf_pkg::bayer_threshold(ycell_reg, xcell_reg);
    assign thr_lhs     = {1'b0, d_reg, 5'b00000};
    assign thr_rhs     = 12'({bayer_b, 1'b1}) * 12'(depth_reg);
    assign unlit_prod  = (k_reg * off_tier_alpha_reg) + {16'b0, dcf_pkg::ROUND_HALF};
    assign feather_sum = {1'b0, border_alpha_reg} + 17'd1;

    // incremental quotient of (K_SPAN * d + depth / 2) / depth
    assign r_sum  = {1'b0, r_reg} + {1'b0, r0_reg};
    assign r_wrap = (r_sum >= {1'b0, depth_reg});

    assign red_prod = color_reg[15:11] * alpha_reg;
    assign grn_prod = color_reg[10:5] * alpha_reg;
    assign blu_prod = color_reg[4:0] * alpha_reg;
    assign red_rnd  = {1'b0, red_prod} + {6'b0, dcf_pkg::ROUND_HALF};
    assign grn_rnd  = {1'b0, grn_prod} + {7'b0, dcf_pkg::ROUND_HALF};
    assign blu_rnd  = {1'b0, blu_prod} + {6'b0, dcf_pkg::ROUND_HALF};

    always_comb
    begin
        state_next = state_reg;
        y_next     = y_reg;
        end_next   = end_reg;
        d_next     = d_reg;
        depth_next = depth_reg;
        top_next   = top_reg;
        color_next = color_reg;
        xcell_next = xcell_reg;
        ycell_next = ycell_reg;
        yrem_next  = yrem_reg;
        q0_next    = q0_reg;
        r0_next    = r0_reg;
        q_next     = q_reg;
        r_next     = r_reg;
        k_next     = k_reg;
        lit_next   = lit_reg;
        alpha_next = alpha_reg;
        out_load   = 1'b0;

        div_req.start    = 1'b0;
        div_req.dividend = {6'b0, column_x};
        div_req.divisor  = {3'b000, cs_eff};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    color_next = color;
                    if (x_off)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (depth_pos)
                    begin
                        top_next      = top_c[5:0];
                        y_next        = top_c[5:0];
                        end_next      = floor_m1[5:0];
                        depth_next    = depth_s[6:0];
                        d_next        = '0;
                        div_req.start = 1'b1;
                        state_next    = S_DIVX;
                    end
                    else if (top_in)
                    begin
                        // empty span: border word only
                        y_next     = top_c[5:0];
                        end_next   = top_c[5:0];
                        alpha_next = border_alpha_reg;
                        state_next = S_PIX;
                    end
                end
            end
            S_DIVX:
            begin
                div_req.dividend = {10'b0, top_reg};
                if (div_rsp.done)
                begin
                    xcell_next    = div_rsp.quotient[1:0];
                    div_req.start = 1'b1;
                    state_next    = S_DIVY;
                end
            end
            S_DIVY:
            begin
                div_req.dividend = dcf_pkg::K_SPAN;
                div_req.divisor  = depth_reg;
                if (div_rsp.done)
                begin
                    ycell_next    = div_rsp.quotient[1:0];
                    yrem_next     = div_rsp.remainder[3:0];
                    div_req.start = 1'b1;
                    state_next    = S_DIVK;
                end
            end
            S_DIVK:
            begin
                div_req.dividend = dcf_pkg::K_SPAN;
                div_req.divisor  = depth_reg;
                if (div_rsp.done)
                begin
                    q0_next    = div_rsp.quotient;
                    r0_next    = div_rsp.remainder;
                    q_next     = '0;
                    r_next     = {1'b0, depth_reg[6:1]};
                    state_next = S_ROWA;
                end
            end
            S_ROWA:
            begin
                k_next     = dcf_pkg::K_BASE + q_reg;
                lit_next   = (thr_lhs > thr_rhs);
                state_next = S_ROWM;
            end
            S_ROWM:
            begin
                priority if (d_reg == 6'd0)
                    alpha_next = border_alpha_reg;
                else if (d_reg == 6'd1)
                    alpha_next = feather_sum[16:1];
                else if (lit_reg)
                    alpha_next = k_reg;
                else
                    alpha_next = unlit_prod[31:16];
                state_next = S_PIX;
            end
            S_PIX:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (row_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // advance one row: y, d, Bayer cell row and the ramp quotient
                        y_next = y_reg + 6'd1;
                        d_next = d_reg + 6'd1;
                        if (yrem_reg + 4'd1 == cs_eff)
                        begin
                            yrem_next  = '0;
                            ycell_next = ycell_reg + 2'd1;
                        end
                        else
                        begin
                            yrem_next = yrem_reg + 4'd1;
                        end
                        r_next     = r_wrap ? 7'(r_sum - {1'b0, depth_reg}) : r_sum[6:0];
                        q_next     = q_reg + q0_reg + {15'b0, r_wrap};
                        state_next = S_ROWA;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output word register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        row_next       = row_reg;
        pixel_next     = pixel_reg;
        last_next      = last_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            row_next       = y_reg;
            pixel_next     = {red_rnd[20:16], grn_rnd[21:16], blu_rnd[20:16]};
            last_next      = row_last;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg     <= y_next;
        end_reg   <= end_next;
        d_reg     <= d_next;
        depth_reg <= depth_next;
        top_reg   <= top_next;
        color_reg <= color_next;
        xcell_reg <= xcell_next;
        ycell_reg <= ycell_next;
        yrem_reg  <= yrem_next;
        q0_reg    <= q0_next;
        r0_reg    <= r0_next;
        q_reg     <= q_next;
        r_reg     <= r_next;
        k_reg     <= k_next;
        lit_reg   <= lit_next;
        alpha_reg <= alpha_next;
        row_reg   <= row_next;
        pixel_reg <= pixel_next;
        last_reg  <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign row       = row_reg;
    assign pixel     = pixel_reg;
    assign last      = last_reg;

    // ---------------- assertions ----------------
    a_div_done_in_setup: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIVX || state_reg == S_DIVY || state_reg == S_DIVK))
        else $error("divider finished outside the setup states");

    a_ramp_rem_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROWA) |-> (r_reg < depth_reg))
        else $error("ramp remainder not below depth");

    a_ramp_quot_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROWA) |-> (q_reg < dcf_pkg::K_SPAN))
        else $error("ramp quotient would overflow alpha");

    a_last_ends_request: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && row_last) |=> (state_reg == S_IDLE))
        else $error("request continued after its last word");

endmodule

FILE: tb/dcf_column_checker.sv
// Checker for dithered_column_fill_core: mirrors the register file from the APB port,
// predicts the pixel words of each accepted column request and compares them in order.
// Depends on dcf_pkg for the register indexes and reset values.
module dcf_column_checker #(
    parameter int MAX_H = dcf_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_W = dcf_pkg::MAX_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [9:0]  column_x,
    input  logic [7:0]  top_row,
    input  logic [8:0]  floor_row,
    input  logic [15:0] color,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [5:0]  row,
    input  logic [15:0] pixel,
    input  logic        last,
    output int          mismatches,
    output int          words_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint RAMP_BASE = 19661;
    localparam longint RAMP_SPAN = 45875;
    // 4x4 ordered-dither thresholds, entry (cy*4 + cx) in nibble cy*4 + cx
    localparam logic [63:0] DITHER = 64'h5D7F_91B3_6E4C_A280;

    typedef struct packed {
        logic [5:0]  row;
        logic [15:0] pixel;
        logic        last;
    } pix_word_t;

    pix_word_t   column_words[$];
    logic [3:0]  cell_r;
    logic [10:0] width_r;
    logic [6:0]  height_r;
    logic [15:0] off_r;
    logic [15:0] border_r;

    initial mismatches = 0;

    task automatic report_mismatch(input string what);
        $display("dcf_column_checker: %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // Scale each RGB565 channel by a Q0.16 alpha with round-half-up
    function automatic logic [15:0] shade(input logic [15:0] c, input longint unsigned a);
        longint unsigned r, g, b;
        r = (longint'(c[15:11]) * a + 32768) >> 16;
        g = (longint'(c[10:5]) * a + 32768) >> 16;
        b = (longint'(c[4:0]) * a + 32768) >> 16;
        return {r[4:0], g[5:0], b[4:0]};
    endfunction

    function automatic void predict_column(input logic [9:0] x, input logic signed [7:0] t,
                                           input logic signed [8:0] f, input logic [15:0] c);
        int w, h, top, flr, depth, cs, xi, dither_idx;
        longint d, k, a;
        pix_word_t wd;
        w = (int'(width_r) > MAX_W) ? MAX_W : int'(width_r);
        h = (int'(height_r) > MAX_H) ? MAX_H : int'(height_r);
        xi = int'(x);
        if (xi >= w)
            return;
        top = t;
        flr = f;
        if (flr > h)
            flr = h;
        if (top < 0)
            top = 0;
        depth = flr - top;
        if (depth <= 0)
        begin
            // empty span: only the border row, if it lies on the canvas
            if (top < h)
            begin
                wd.row = 6'(top);
                wd.pixel = shade(c, longint'(border_r));
                wd.last = 1'b1;
                column_words.push_back(wd);
            end
            return;
        end
        cs = (cell_r == 4'd0) ? 1 : int'(cell_r);
        for (int y = top; y < flr; y++)
        begin
            if (y == top)
            begin
                a = longint'(border_r);
            end
            else if (y == top + 1)
            begin
                a = (longint'(border_r) + 1) >> 1;
            end
            else
            begin
                d = y - top;
                k = RAMP_BASE + (RAMP_SPAN * d + depth / 2) / depth;
                dither_idx = ((y / cs) % 4) * 4 + (xi / cs) % 4;
                if (32 * d > (2 * longint'(DITHER[dither_idx*4 +: 4]) + 1) * depth)
                    a = k;
                else
                    a = (k * longint'(off_r) + 32768) >> 16;
            end
            wd.row = 6'(y);
            wd.pixel = shade(c, a);
            wd.last = (y == flr - 1);
            column_words.push_back(wd);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        pix_word_t want;
        if (!rst_n)
        begin
            cell_r   = dcf_pkg::CELL_SIZE_RST;
            width_r  = dcf_pkg::CANVAS_WIDTH_RST;
            height_r = dcf_pkg::CANVAS_HEIGHT_RST;
            off_r    = dcf_pkg::OFF_TIER_ALPHA_RST;
            border_r = dcf_pkg::BORDER_ALPHA_RST;
            column_words.delete();
            words_due <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    dcf_pkg::REG_CELL_SIZE:      cell_r   = pwdata[3:0];
                    dcf_pkg::REG_CANVAS_WIDTH:   width_r  = pwdata[10:0];
                    dcf_pkg::REG_CANVAS_HEIGHT:  height_r = pwdata[6:0];
                    dcf_pkg::REG_OFF_TIER_ALPHA: off_r    = pwdata[15:0];
                    dcf_pkg::REG_BORDER_ALPHA:   border_r = pwdata[15:0];
                    default: ;
                endcase
            end
            // queue the new request first: its words come out no earlier than next cycle
            if (in_valid && !in_stall)
                predict_column(column_x, top_row, floor_row, color);
            if (out_valid && !out_stall)
            begin
                if (column_words.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected word row %0d pixel %h last %b",
                                              row, pixel, last));
                end
                else
                begin
                    want = column_words.pop_front();
                    if (row !== want.row)
                        report_mismatch($sformatf("row %0d, want %0d", row, want.row));
                    if (pixel !== want.pixel)
                        report_mismatch($sformatf("row %0d pixel %h, want %h",
                                                  want.row, pixel, want.pixel));
                    if (last !== want.last)
                        report_mismatch($sformatf("row %0d last %b, want %b",
                                                  want.row, last, want.last));
                end
            end
            words_due <= column_words.size();
        end
    end

endmodule

FILE: tb/tb.sv
// Testbench top for dithered_column_fill_core: clock, reset, register setup over APB,
// column requests with random pacing on both channels, watchdog and verdict.
// Depends on dcf_pkg, the core and dcf_column_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 300;
    localparam int WATCHDOG      = 3000;
    localparam int N_SETTINGS    = 8;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [4:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [9:0]  column_x  = '0;
    logic [7:0]  top_row   = '0;
    logic [8:0]  floor_row = '0;
    logic [15:0] color     = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [5:0]  row;
    logic [15:0] pixel;
    logic        last;

    int fail_cnt;
    int words_due;
    int quiet_cycles = 0;
    bit steady = 1'b0;
    int cur_w;
    int cur_h;

    dithered_column_fill_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .column_x  (column_x),
        .top_row   (top_row),
        .floor_row (floor_row),
        .color     (color),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .row       (row),
        .pixel     (pixel),
        .last      (last)
    );

    dcf_column_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .column_x   (column_x),
        .top_row    (top_row),
        .floor_row  (floor_row),
        .color      (color),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .row        (row),
        .pixel      (pixel),
        .last       (last),
        .mismatches (fail_cnt),
        .words_due  (words_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    initial
    begin : sink_pacing
        int n;
        @(posedge clk);
        forever
        begin
            n = steady ? 0 : idle_len();
            if (n != 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic apb_write(input logic [2:0] idx, input int data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(data);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Hold the word until accepted, then idle for a random gap
    task automatic send_request(input int x, input int t, input int f, input int c);
        int gap;
        in_valid  <= 1'b1;
        column_x  <= 10'(x);
        top_row   <= 8'(t);
        floor_row <= 9'(f);
        color     <= 16'(c);
        do @(posedge clk); while (in_stall);
        gap = steady ? 0 : idle_len();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drain all expected words, then let any wordless request finish
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (words_due != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_setting(input int p, output int items);
        int cs, w, h, off, bord;
        off  = $urandom_range(0, 65535);
        bord = $urandom_range(0, 65535);
        case (p)
            0: begin cs = 2;  w = 1024; h = 64;  off = 0;     bord = 65535; items = 55; end
            1: begin cs = 15; w = 2047; h = 127; off = 65535; bord = 0;     items = 50; end
            2: begin cs = 0;  w = 1;    h = 1;                bord = 1;     items = 40; end
            3: begin cs = 8;  w = 512;  h = 17;                             items = 55; end
            4: begin cs = 3;  w = 300;  h = 0;                              items = 10; end
            5: begin cs = 1;  w = 240;  h = 64;                             items = 60; end
            6: begin cs = 4;  w = 100;  h = 32;  off = 1;     bord = 65534; items = 60; end
            default: begin cs = 6; w = 0; h = 40;                           items = 10; end
        endcase
        apb_write(dcf_pkg::REG_CELL_SIZE, cs);
        apb_write(dcf_pkg::REG_CANVAS_WIDTH, w);
        apb_write(dcf_pkg::REG_CANVAS_HEIGHT, h);
        apb_write(dcf_pkg::REG_OFF_TIER_ALPHA, off);
        apb_write(dcf_pkg::REG_BORDER_ALPHA, bord);
        cur_w = (w > 1024) ? 1024 : w;
        cur_h = (h > 64) ? 64 : h;
    endtask

    // Mostly spans that start on the canvas; some clamped, empty or wild
    task automatic random_request();
        int x, t, f, h1;
        h1 = (cur_h > 0) ? cur_h : 1;
        if (cur_w > 0 && $urandom_range(0, 99) < 85)
            x = $urandom_range(0, cur_w - 1);
        else
            x = $urandom_range(0, 1023);
        case ($urandom_range(0, 9))
            0: t = int'($urandom_range(0, 127)) - 128;
            1: t = int'($urandom_range(0, 255)) - 128;
            default: t = $urandom_range(0, h1 - 1);
        endcase
        case ($urandom_range(0, 9))
            0: f = int'($urandom_range(0, 511)) - 256;
            1: f = t;
            2: f = t + 1;
            default: f = ((t < 0) ? 0 : t) + int'($urandom_range(1, 64));
        endcase
        send_request(x, t, f, int'($urandom_range(0, 65535)));
    endtask

    initial
    begin : stimulus
        int items;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        cur_w = 240;
        cur_h = 64;

        // directed: reset registers, canvas 240 x 64
        send_request(0, 0, 64, 16'hFFFF);
        send_request(239, -64, 128, 16'hFFFF);
        send_request(240, 0, 10, 16'h1234);
        send_request(1023, 0, 10, 16'h1234);
        send_request(17, -1, -64, 16'hF800);
        send_request(33, 10, 10, 16'h07E0);
        send_request(5, 64, 64, 16'h001F);
        send_request(6, 63, 0, 16'hFFFF);
        send_request(7, 5, 6, 16'hFFFF);
        send_request(8, 5, 7, 16'hFFFF);
        send_request(9, 20, 23, 16'h0000);
        send_request(10, -128, 255, 16'hAAAA);
        send_request(11, 127, -256, 16'h5555);
        send_request(12, 62, 64, 16'hFFFF);
        send_request(3, 0, 63, 16'h7BEF);
        send_request(200, 30, 64, 16'h8410);
        send_request(1, 63, 64, 16'hFFFF);
        send_request(2, -5, 1, 16'hFFFF);

        for (int p = 0; p < N_SETTINGS; p++)
        begin
            settle();
            apply_setting(p, items);
            steady = (p % 3 == 2);
            repeat (items) random_request();
        end
        settle();

        if (fail_cnt == 0 && words_due == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
